[rtl/core/rhd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramped dual H-bridge drive package
// Shared types and constants for the drive block: word formats, the
// configuration register map and reset values.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int unsigned LevelW = 9;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [DutyW-1:0] DutyMax       = 8'hFF;
  localparam logic [7:0]       StepReset     = 8'd10;
  localparam logic [7:0]       DeadbandReset = 8'd10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepSize   = 2'd0,
    CfgDeadband   = 2'd1,
    CfgMotorPower = 2'd2
  } cfg_idx_e;

  typedef logic signed [LevelW-1:0] level_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [7:0] step_size;
    logic [7:0] deadband;
    logic       motor_power;
  } cfg_t;

  typedef struct packed {
    level_t m1_target;
    level_t m2_target;
    logic   ramp;
  } in_word_t;

  // Bridge drive for one motor.
  typedef struct packed {
    logic             in_a;
    logic             in_b;
    logic [DutyW-1:0] duty;
  } drive_t;

  typedef struct packed {
    drive_t m1;
    drive_t m2;
    logic   at_target;
    logic   standby_n;
  } out_word_t;

endpackage

[rtl/core/rhd_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive command channel
// Valid/ready channel carrying the two motor targets and the ramp flag.
// ----------------------------------------------------------------------------
interface rhd_in_if;
  logic            valid;
  logic            ready;
  rhd_pkg::level_t m1_target;
  rhd_pkg::level_t m2_target;
  logic            ramp;

  modport source (output valid, output m1_target, output m2_target, output ramp,
                  input ready);
  modport sink   (input valid, input m1_target, input m2_target, input ramp,
                  output ready);
endinterface

[rtl/core/rhd_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bridge drive channel
// Valid/ready channel carrying the pin levels and duties for both bridges.
// ----------------------------------------------------------------------------
interface rhd_out_if;
  logic                          valid;
  logic                          ready;
  logic                          m1_in_a;
  logic                          m1_in_b;
  logic [rhd_pkg::DutyW-1:0]     m1_duty;
  logic                          m2_in_a;
  logic                          m2_in_b;
  logic [rhd_pkg::DutyW-1:0]     m2_duty;
  logic                          at_target;
  logic                          standby_n;

  modport source (output valid, output m1_in_a, output m1_in_b, output m1_duty,
                  output m2_in_a, output m2_in_b, output m2_duty,
                  output at_target, output standby_n, input ready);
  modport sink   (input valid, input m1_in_a, input m1_in_b, input m1_duty,
                  input m2_in_a, input m2_in_b, input m2_duty,
                  input at_target, input standby_n, output ready);
endinterface

[rtl/core/rhd_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface rhd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rhd_pkg::CfgIdxW-1:0]    index;
  logic [rhd_pkg::CfgDataW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/rhd_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds step size, deadband and motor power; writes to unused indexes are
// dropped.
// ----------------------------------------------------------------------------
module rhd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  rhd_cfg_if.sink       cfg_i,
  output rhd_pkg::cfg_t cfg_o
);

  rhd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (rhd_pkg::cfg_idx_e'(cfg_i.index))
        rhd_pkg::CfgStepSize:   cfg_d.step_size   = cfg_i.data;
        rhd_pkg::CfgDeadband:   cfg_d.deadband    = cfg_i.data;
        rhd_pkg::CfgMotorPower: cfg_d.motor_power = cfg_i.data[0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size   <= rhd_pkg::StepReset;
      cfg_q.deadband    <= rhd_pkg::DeadbandReset;
      cfg_q.motor_power <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/rhd_level.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor level ramp
// Stores one motor level and moves it toward the target, limited by the
// step size when ramping.
// ----------------------------------------------------------------------------
module rhd_level (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  rhd_pkg::level_t target_i,
  input  logic            ramp_i,
  input  logic [7:0]      step_size_i,
  output rhd_pkg::level_t level_o,
  output logic            at_target_o
);

  rhd_pkg::level_t   level_q, level_d;
  logic signed [9:0] diff;
  logic [9:0]        span;
  logic              far;

  always_comb begin
    diff = 10'(signed'({target_i[8], target_i})) - 10'(signed'({level_q[8], level_q}));
    span = diff[9] ? 10'(-diff) : 10'(diff);
    far  = span > {2'b00, step_size_i};
    if (!ramp_i || !far) begin
      level_d = target_i;
    end else if (diff[9]) begin
      level_d = rhd_pkg::level_t'(level_q - signed'({1'b0, step_size_i}));
    end else begin
      level_d = rhd_pkg::level_t'(level_q + signed'({1'b0, step_size_i}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
    end else if (en_i) begin
      level_q <= level_d;
    end
  end

  assign level_o     = level_d;
  assign at_target_o = (level_d == target_i);

endmodule

[rtl/core/rhd_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bridge decode
// Turns a signed motor level into direction pins and a clamped PWM duty.
// ----------------------------------------------------------------------------
module rhd_decode (
  input  rhd_pkg::level_t level_i,
  input  logic [7:0]      deadband_i,
  output rhd_pkg::drive_t drive_o
);

  logic                      rev;
  logic [8:0]                mag;
  logic [rhd_pkg::DutyW-1:0] duty;

  always_comb begin
    rev  = level_i[8];
    mag  = rev ? 9'(-level_i) : 9'(level_i);
    duty = mag[8] ? rhd_pkg::DutyMax : mag[7:0];
    drive_o.duty = duty;
    if (duty < deadband_i) begin
      drive_o.in_a = 1'b0;
      drive_o.in_b = 1'b0;
    end else begin
      drive_o.in_a = !rev;
      drive_o.in_b = rev;
    end
  end

endmodule

[rtl/core/ramped_dual_hbridge_drive_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ramped dual H-bridge drive unit
// Slew-limited speed control and bridge pin decode for two DC motors.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one command word per tick: two signed targets and a ramp
//   flag. out_o returns exactly one drive word per command, in order: the
//   direction pins and PWM duty of each bridge, an at-target flag and the
//   standby pin. cfg_i writes step size (0), deadband (1) and motor power
//   (2); writes to index 3 are dropped. Configure only while the block is
//   idle.
//   A command is latched in an input register, then the ramp and decode
//   run combinationally into the output register, which holds the drive
//   word; one word is taken every cycle while out_o is ready.
//   If out_o stalls, the output register holds its word and the input
//   register still takes one more command before in_i.ready drops.
//   Reset clears both motor levels to zero, empties both registers and loads
//   step size 10, deadband 10 and motor power off.
// ----------------------------------------------------------------------------
module ramped_dual_hbridge_drive_unit (
  input  logic     clk_i,
  input  logic     rst_ni,
  rhd_in_if.sink   in_i,
  rhd_out_if.source out_o,
  rhd_cfg_if.sink  cfg_i
);

  rhd_pkg::cfg_t      cfg;
  rhd_pkg::in_word_t  in_q;
  rhd_pkg::out_word_t out_q, out_d;
  rhd_pkg::level_t    m1_level, m2_level;
  logic               in_valid_q, out_valid_q;
  logic               advance;
  logic               m1_at, m2_at;

  rhd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // The stored word moves forward when the output register is free or drains.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.m1_target <= in_i.m1_target;
      in_q.m2_target <= in_i.m2_target;
      in_q.ramp      <= in_i.ramp;
    end
  end

  rhd_level u_m1_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .target_i    (in_q.m1_target),
    .ramp_i      (in_q.ramp),
    .step_size_i (cfg.step_size),
    .level_o     (m1_level),
    .at_target_o (m1_at)
  );

  rhd_level u_m2_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .target_i    (in_q.m2_target),
    .ramp_i      (in_q.ramp),
    .step_size_i (cfg.step_size),
    .level_o     (m2_level),
    .at_target_o (m2_at)
  );

  rhd_decode u_m1_decode (
    .level_i    (m1_level),
    .deadband_i (cfg.deadband),
    .drive_o    (out_d.m1)
  );

  rhd_decode u_m2_decode (
    .level_i    (m2_level),
    .deadband_i (cfg.deadband),
    .drive_o    (out_d.m2)
  );

  assign out_d.at_target = m1_at && m2_at;
  assign out_d.standby_n = cfg.motor_power;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.m1_in_a   = out_q.m1.in_a;
  assign out_o.m1_in_b   = out_q.m1.in_b;
  assign out_o.m1_duty   = out_q.m1.duty;
  assign out_o.m2_in_a   = out_q.m2.in_a;
  assign out_o.m2_in_b   = out_q.m2.in_b;
  assign out_o.m2_duty   = out_q.m2.duty;
  assign out_o.at_target = out_q.at_target;
  assign out_o.standby_n = out_q.standby_n;

endmodule
